// File: hw/rtl/point_in_figure_table_test_top_defines.svh
// Assertion macros shared by the figure table block.
`ifndef POINT_IN_FIGURE_TABLE_TEST_TOP_DEFINES_SVH
`define POINT_IN_FIGURE_TABLE_TEST_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIFT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PIFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pift_pkg.sv
// Types, codes and helper functions of the figure table block.
package pift_pkg;

  localparam int MAX_FIGURES_DEF = 16;
  localparam int FIG_NUM_W = 5;
  localparam int PNUM_W = 16;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] KIND_RECT   = 2'd0;
  localparam logic [1:0] KIND_CIRCLE = 2'd1;
  localparam logic [1:0] KIND_TRI    = 2'd2;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_ADDED   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [5:0][31:0] c;
  } fig_t;

  typedef struct packed {
    logic start;
    logic ack;
  } tst_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } tst_stat_t;

  function automatic logic signed [32:0] sdiff(logic [31:0] a, logic [31:0] b);
    return $signed({a[31], a}) - $signed({b[31], b});
  endfunction

endpackage

// File: hw/rtl/pift_req_if.sv
// Request channel: command, figure data and query point.
interface pift_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  fig_kind;
  logic [31:0] coord0;
  logic [31:0] coord1;
  logic [31:0] coord2;
  logic [31:0] coord3;
  logic [31:0] coord4;
  logic [31:0] coord5;
  logic [31:0] point_x;
  logic [31:0] point_y;

  modport source (output valid, cmd, fig_kind, coord0, coord1, coord2, coord3,
                  coord4, coord5, point_x, point_y, input ready);
  modport sink (input valid, cmd, fig_kind, coord0, coord1, coord2, coord3,
                coord4, coord5, point_x, point_y, output ready);
endinterface

// File: hw/rtl/pift_rsp_if.sv
// Response channel: one result item per handshake.
interface pift_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] point_number;
  logic [4:0]  figure_number;
  logic        last;

  modport source (output valid, status, point_number, figure_number, last,
                  input ready);
  modport sink (input valid, status, point_number, figure_number, last,
                output ready);
endinterface

// File: hw/rtl/point_in_figure_table_test_top.sv
// Top level of the figure table with point containment queries.
// The req channel takes one command item: clear, add figure or query point.
// The rsp channel gives result items; the final one of each command has last set.
// Clear and add are taken only when the output register is free and give one
// result in the next cycle; a command code of three is taken and gives none.
// A query walks the whole chain of figure cells, which rotates by one cell
// per figure so that cell zero always feeds the shared multiply-compare unit.
// A rectangle or an unknown kind is tested by comparison alone, a circle and a
// triangle by the multiply steps of the shared unit; each unused table slot is
// passed over without a test, and the final result follows the scan.
// Hits are delivered in table order; when the receiver stalls, the scan waits
// on the output register and no result is lost.
// Reset empties the table, sets the query number to one and drops any result.
// Figure storage is not cleared by reset; only stored figures are ever read.
module point_in_figure_table_test_top #(
  parameter int MAX_FIGURES = pift_pkg::MAX_FIGURES_DEF
) (
  input logic      clk,
  input logic      rst,
  pift_req_if.sink req,
  pift_rsp_if.source rsp
);
  import pift_pkg::*;
  `include "point_in_figure_table_test_top_defines.svh"

  localparam int CW = $clog2(MAX_FIGURES + 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_FINAL = 3'b100
  } state_t;

  state_t                 state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          fi;
  logic [PNUM_W-1:0]      pnum;
  logic [31:0]            qx;
  logic [31:0]            qy;
  logic                   pend_valid;
  logic [FIG_NUM_W-1:0]   pend_num;
  logic                   out_valid;
  logic [2:0]             out_status;
  logic [PNUM_W-1:0]      out_pnum;
  logic [FIG_NUM_W-1:0]   out_fnum;
  logic                   out_last;

  logic                   slot_free;
  logic                   accept;
  logic                   add_go;
  logic                   shift;
  logic                   fi_active;
  logic                   emit;
  logic [2:0]             emit_status;
  logic [PNUM_W-1:0]      emit_pnum;
  logic [FIG_NUM_W-1:0]   emit_fnum;
  logic                   emit_last;
  logic                   hit_flush;
  fig_t                   new_fig;
  fig_t                   cell_fig [MAX_FIGURES];
  tst_ctrl_t              tst_ctrl;
  tst_stat_t              tst_stat;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept = req.valid && req.ready;
  assign add_go = accept && req.cmd == CMD_ADD && count < CW'(MAX_FIGURES);
  assign fi_active = fi < count;

  assign new_fig.kind = req.fig_kind;
  assign new_fig.c = {req.coord5, req.coord4, req.coord3, req.coord2, req.coord1,
                      req.coord0};

  genvar i;
  for (i = 0; i < MAX_FIGURES; i++) begin : g_cell
    pift_cell u_cell (
      .clk      (clk),
      .load     (add_go && count == CW'(i)),
      .load_fig (new_fig),
      .shift    (shift),
      .shift_in (cell_fig[(i + 1) % MAX_FIGURES]),
      .fig      (cell_fig[i])
    );
  end

  pift_test u_test (
    .clk  (clk),
    .rst  (rst),
    .fig  (cell_fig[0]),
    .px   (qx),
    .py   (qy),
    .ctrl (tst_ctrl),
    .stat (tst_stat)
  );

  assign hit_flush = tst_stat.done && tst_stat.hit && pend_valid;

  always_comb begin
    tst_ctrl.start = 1'b0;
    tst_ctrl.ack = 1'b0;
    shift = 1'b0;
    emit = 1'b0;
    emit_status = ST_HIT;
    emit_pnum = pnum;
    emit_fnum = pend_num;
    emit_last = 1'b1;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.cmd)
            CMD_CLEAR: begin
              emit = 1'b1;
              emit_status = ST_CLEARED;
              emit_pnum = '0;
              emit_fnum = '0;
            end
            CMD_ADD: begin
              emit = 1'b1;
              emit_pnum = '0;
              if (add_go) begin
                emit_status = ST_ADDED;
                emit_fnum = FIG_NUM_W'(count) + FIG_NUM_W'(1);
              end else begin
                emit_status = ST_FULL;
                emit_fnum = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!fi_active) begin
          shift = 1'b1;
        end else if (tst_stat.done) begin
          if (!hit_flush || slot_free) begin
            tst_ctrl.ack = 1'b1;
            shift = 1'b1;
            emit = hit_flush;
            emit_last = 1'b0;
          end
        end else if (!tst_stat.busy) begin
          tst_ctrl.start = 1'b1;
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          emit = 1'b1;
          if (!pend_valid) begin
            emit_status = ST_MISS;
            emit_fnum = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      pnum <= PNUM_W'(1);
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (req.cmd)
              CMD_CLEAR: begin
                count <= '0;
                pnum <= PNUM_W'(1);
              end
              CMD_ADD: begin
                if (add_go) begin
                  count <= count + CW'(1);
                end
              end
              CMD_QUERY: begin
                state <= S_SCAN;
                pend_valid <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (shift) begin
            if (tst_ctrl.ack && tst_stat.hit) begin
              pend_valid <= 1'b1;
            end
            if (fi == CW'(MAX_FIGURES - 1)) begin
              state <= S_FINAL;
            end
          end
        end
        S_FINAL: begin
          if (slot_free) begin
            state <= S_IDLE;
            pend_valid <= 1'b0;
            pnum <= (pnum == '1) ? PNUM_W'(1) : pnum + PNUM_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.cmd == CMD_QUERY) begin
      qx <= req.point_x;
      qy <= req.point_y;
      fi <= '0;
    end else if (shift) begin
      fi <= fi + CW'(1);
    end
    if (tst_ctrl.ack && tst_stat.hit) begin
      pend_num <= FIG_NUM_W'(fi) + FIG_NUM_W'(1);
    end
    if (emit) begin
      out_status <= emit_status;
      out_pnum <= emit_pnum;
      out_fnum <= emit_fnum;
      out_last <= emit_last;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.point_number = out_pnum;
  assign rsp.figure_number = out_fnum;
  assign rsp.last = out_last;

  `PIFT_ASSERT_SAME(a_emit_free, emit, slot_free, "Result item written over a waiting one.")
  `PIFT_ASSERT_SAME(a_done_scan, tst_stat.done, state == S_SCAN, "Test result outside a scan.")
  `PIFT_ASSERT_SAME(a_count_max, 1'b1, count <= CW'(MAX_FIGURES), "Figure count overflow.")
  `PIFT_ASSERT_NEXT(a_start_busy, tst_ctrl.start, tst_stat.busy, "Test unit did not start.")
endmodule

// File: hw/rtl/pift_cell.sv
// One storage cell of the figure chain.
module pift_cell (
  input  logic          clk,
  input  logic          load,
  input  pift_pkg::fig_t load_fig,
  input  logic          shift,
  input  pift_pkg::fig_t shift_in,
  output pift_pkg::fig_t fig
);
  import pift_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      fig <= load_fig;
    end else if (shift) begin
      fig <= shift_in;
    end
  end
endmodule

// File: hw/rtl/pift_test.sv
// Shared multiply-compare unit that tests one figure against the point.
module pift_test (
  input  logic               clk,
  input  logic               rst,
  input  pift_pkg::fig_t      fig,
  input  logic [31:0]        px,
  input  logic [31:0]        py,
  input  pift_pkg::tst_ctrl_t ctrl,
  output pift_pkg::tst_stat_t stat
);
  import pift_pkg::*;

  logic                busy;
  logic                done;
  logic                hit;
  logic [3:0]          step;
  logic [3:0]          last_step;
  logic signed [65:0]  prod;
  logic signed [66:0]  acc;
  logic signed [66:0]  diff;
  logic                opos;
  logic                oneg;
  logic                bad;
  logic                wrong;
  logic                final_hit;
  logic signed [32:0]  op_a;
  logic signed [32:0]  op_b;
  logic                rect_hit;
  logic                r_pos;

  assign diff = acc - 67'(prod);
  assign wrong = (opos && diff < 0) || (oneg && diff > 0);
  assign r_pos = $signed(fig.c[2]) > 0;
  assign rect_hit = ($signed(px) > $signed(fig.c[0])) && ($signed(px) < $signed(fig.c[2]))
                 && ($signed(py) > $signed(fig.c[3])) && ($signed(py) < $signed(fig.c[1]));

  always_comb begin
    op_a = '0;
    op_b = '0;
    last_step = 4'd0;
    final_hit = 1'b0;
    case (fig.kind)
      KIND_RECT: begin
        final_hit = rect_hit;
      end
      KIND_CIRCLE: begin
        last_step = 4'd3;
        final_hit = r_pos && (acc < 67'(prod));
        case (step)
          4'd0: begin
            op_a = sdiff(px, fig.c[0]);
            op_b = sdiff(px, fig.c[0]);
          end
          4'd1: begin
            op_a = sdiff(py, fig.c[1]);
            op_b = sdiff(py, fig.c[1]);
          end
          4'd2: begin
            op_a = $signed({fig.c[2][31], fig.c[2]});
            op_b = $signed({fig.c[2][31], fig.c[2]});
          end
          default: begin
          end
        endcase
      end
      KIND_TRI: begin
        last_step = 4'd8;
        final_hit = (opos || oneg) && !(bad || wrong);
        case (step)
          4'd0: begin
            op_a = sdiff(fig.c[2], fig.c[0]);
            op_b = sdiff(fig.c[5], fig.c[1]);
          end
          4'd1: begin
            op_a = sdiff(fig.c[3], fig.c[1]);
            op_b = sdiff(fig.c[4], fig.c[0]);
          end
          4'd2: begin
            op_a = sdiff(fig.c[2], fig.c[0]);
            op_b = sdiff(py, fig.c[1]);
          end
          4'd3: begin
            op_a = sdiff(fig.c[3], fig.c[1]);
            op_b = sdiff(px, fig.c[0]);
          end
          4'd4: begin
            op_a = sdiff(fig.c[4], fig.c[2]);
            op_b = sdiff(py, fig.c[3]);
          end
          4'd5: begin
            op_a = sdiff(fig.c[5], fig.c[3]);
            op_b = sdiff(px, fig.c[2]);
          end
          4'd6: begin
            op_a = sdiff(fig.c[0], fig.c[4]);
            op_b = sdiff(py, fig.c[5]);
          end
          4'd7: begin
            op_a = sdiff(fig.c[1], fig.c[5]);
            op_b = sdiff(px, fig.c[4]);
          end
          default: begin
          end
        endcase
      end
      default: begin
        final_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (ctrl.ack) begin
        done <= 1'b0;
      end
      if (ctrl.start) begin
        busy <= 1'b1;
      end else if (busy && step == last_step) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      step <= 4'd0;
    end else if (busy) begin
      step <= step + 4'd1;
      prod <= op_a * op_b;
      if (step == last_step) begin
        hit <= final_hit;
      end
      if (fig.kind == KIND_CIRCLE) begin
        if (step == 4'd1) begin
          acc <= 67'(prod);
        end else if (step == 4'd2) begin
          acc <= acc + 67'(prod);
        end
      end else if (fig.kind == KIND_TRI) begin
        if (step[0]) begin
          acc <= 67'(prod);
        end else if (step == 4'd2) begin
          opos <= diff > 0;
          oneg <= diff < 0;
          bad <= 1'b0;
        end else if (step != 4'd0) begin
          bad <= bad || wrong;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.hit  = hit;
endmodule

// File: dv/point_in_figure_table_test_top_tb.sv
// Self-checking testbench for the figure table block with point queries.
`timescale 1ns / 1ps

module point_in_figure_table_test_top_tb;
  import pift_pkg::*;

  localparam int NFIG = MAX_FIGURES_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;
  localparam logic signed [31:0] UNIT = 32'sh0001_0000;

  typedef struct {
    logic [1:0]  cmd;
    logic [1:0]  kind;
    logic [31:0] c [6];
    logic [31:0] px;
    logic [31:0] py;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] pnum;
    logic [4:0]  fnum;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pift_req_if req_ch ();
  pift_rsp_if rsp_ch ();

  point_in_figure_table_test_top dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cmd_item_t pending_cmds [$];
  result_t   expected_results [$];

  logic [1:0]  table_kind [NFIG];
  longint      table_coord [NFIG][6];
  int          table_count = 0;
  logic [15:0] query_number = 16'd1;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int error_count = 0;
  int query_count = 0;
  int hit_count = 0;
  int full_count = 0;
  int quiet_cycles = 0;
  cmd_item_t drv_item;
  result_t   seen;

  function automatic int cross_sign(longint ax, longint ay, longint bx, longint by,
                                    longint qx, longint qy);
    logic signed [67:0] p1;
    logic signed [67:0] p2;
    logic signed [67:0] a1;
    logic signed [67:0] a2;
    logic signed [67:0] b1;
    logic signed [67:0] b2;
    a1 = bx - ax;
    b1 = qy - ay;
    a2 = by - ay;
    b2 = qx - ax;
    p1 = a1 * b1;
    p2 = a2 * b2;
    if (p1 > p2) return 1;
    if (p1 < p2) return -1;
    return 0;
  endfunction

  function automatic bit figure_contains(int i, longint qx, longint qy);
    longint dx;
    longint dy;
    longint r;
    int o;
    int s1;
    int s2;
    int s3;
    case (table_kind[i])
      KIND_RECT: begin
        return qx > table_coord[i][0] && qx < table_coord[i][2] &&
               qy > table_coord[i][3] && qy < table_coord[i][1];
      end
      KIND_CIRCLE: begin
        r = table_coord[i][2];
        if (r <= 0) return 1'b0;
        dx = qx - table_coord[i][0];
        dy = qy - table_coord[i][1];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dx >= r || dy >= r) return 1'b0;
        return dx * dx + dy * dy < r * r;
      end
      KIND_TRI: begin
        o = cross_sign(table_coord[i][0], table_coord[i][1], table_coord[i][2],
                       table_coord[i][3], table_coord[i][4], table_coord[i][5]);
        if (o == 0) return 1'b0;
        s1 = cross_sign(table_coord[i][0], table_coord[i][1], table_coord[i][2],
                        table_coord[i][3], qx, qy);
        s2 = cross_sign(table_coord[i][2], table_coord[i][3], table_coord[i][4],
                        table_coord[i][5], qx, qy);
        s3 = cross_sign(table_coord[i][4], table_coord[i][5], table_coord[i][0],
                        table_coord[i][1], qx, qy);
        return s1 != -o && s2 != -o && s3 != -o;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic predict_results(input cmd_item_t it);
    longint qx;
    longint qy;
    int hits;
    case (it.cmd)
      CMD_CLEAR: begin
        table_count = 0;
        query_number = 16'd1;
        expected_results.push_back('{ST_CLEARED, 16'd0, 5'd0, 1'b1});
      end
      CMD_ADD: begin
        if (table_count >= NFIG) begin
          full_count++;
          expected_results.push_back('{ST_FULL, 16'd0, 5'd0, 1'b1});
        end else begin
          table_kind[table_count] = it.kind;
          for (int j = 0; j < 6; j++) table_coord[table_count][j] = $signed(it.c[j]);
          table_count++;
          expected_results.push_back('{ST_ADDED, 16'd0, 5'(table_count), 1'b1});
        end
      end
      CMD_QUERY: begin
        qx = $signed(it.px);
        qy = $signed(it.py);
        hits = 0;
        query_count++;
        for (int i = 0; i < table_count; i++) begin
          if (figure_contains(i, qx, qy)) begin
            expected_results.push_back('{ST_HIT, query_number, 5'(i + 1), 1'b0});
            hits++;
          end
        end
        hit_count += hits;
        if (hits == 0) begin
          expected_results.push_back('{ST_MISS, query_number, 5'd0, 1'b1});
        end else begin
          expected_results[$].last = 1'b1;
        end
        query_number = (query_number == 16'hFFFF) ? 16'd1 : query_number + 16'd1;
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(16 * UNIT) - 8 * UNIT;
  endfunction

  task automatic push_cmd(input logic [1:0] cmd, input logic [1:0] kind,
                          input logic [31:0] c0, input logic [31:0] c1,
                          input logic [31:0] c2, input logic [31:0] c3,
                          input logic [31:0] c4, input logic [31:0] c5,
                          input logic [31:0] px, input logic [31:0] py);
    cmd_item_t it;
    it.cmd = cmd;
    it.kind = kind;
    it.c[0] = c0;
    it.c[1] = c1;
    it.c[2] = c2;
    it.c[3] = c3;
    it.c[4] = c4;
    it.c[5] = c5;
    it.px = px;
    it.py = py;
    pending_cmds.push_back(it);
  endtask

  task automatic push_query(input logic [31:0] px, input logic [31:0] py);
    push_cmd(CMD_QUERY, 2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, px, py);
  endtask

  task automatic push_random(input int count);
    int pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        push_cmd(CMD_CLEAR, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 7) begin
        push_cmd(CMD_NONE, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom);
      end else if (pick < 40) begin
        push_cmd(CMD_ADD, $urandom_range(9) == 0 ? KIND_UNKNOWN : 2'($urandom_range(2)),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), $urandom, $urandom);
      end else begin
        push_query(rand_coord(), rand_coord());
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_cmds.size() != 0 || req_ch.valid || expected_results.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = pending_cmds.pop_front();
        predict_results(drv_item);
        req_ch.valid <= 1'b1;
        req_ch.cmd <= drv_item.cmd;
        req_ch.fig_kind <= drv_item.kind;
        req_ch.coord0 <= drv_item.c[0];
        req_ch.coord1 <= drv_item.c[1];
        req_ch.coord2 <= drv_item.c[2];
        req_ch.coord3 <= drv_item.c[3];
        req_ch.coord4 <= drv_item.c[4];
        req_ch.coord5 <= drv_item.c[5];
        req_ch.point_x <= drv_item.px;
        req_ch.point_y <= drv_item.py;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen = '{rsp_ch.status, rsp_ch.point_number, rsp_ch.figure_number, rsp_ch.last};
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result %p", $time, seen);
        end else if (expected_results[0] != seen) begin
          error_count++;
          $display("%0t: expected %p, actual %p", $time, expected_results[0], seen);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_CLEAR;
    req_ch.fig_kind = KIND_RECT;
    req_ch.coord0 = '0;
    req_ch.coord1 = '0;
    req_ch.coord2 = '0;
    req_ch.coord3 = '0;
    req_ch.coord4 = '0;
    req_ch.coord5 = '0;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    rsp_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    push_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    push_cmd(CMD_ADD, KIND_RECT, -UNIT, UNIT, UNIT, -UNIT, 0, 0, 0, 0);
    push_cmd(CMD_ADD, KIND_CIRCLE, 0, 0, UNIT, 0, 0, 0, 0, 0);
    push_cmd(CMD_ADD, KIND_TRI, 0, 0, 2 * UNIT, 0, 0, 2 * UNIT, 0, 0);
    push_cmd(CMD_ADD, KIND_UNKNOWN, -UNIT, UNIT, UNIT, -UNIT, 0, 0, 0, 0);
    push_cmd(CMD_ADD, KIND_TRI, 0, 0, UNIT, UNIT, 2 * UNIT, 2 * UNIT, 0, 0);
    push_cmd(CMD_ADD, KIND_RECT, UNIT, UNIT, -UNIT, -UNIT, 0, 0, 0, 0);
    push_cmd(CMD_ADD, KIND_CIRCLE, 0, 0, -UNIT, 0, 0, 0, 0, 0);
    push_cmd(CMD_ADD, KIND_RECT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    push_cmd(CMD_ADD, KIND_TRI, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    push_cmd(CMD_ADD, KIND_CIRCLE, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
             0, 0, 0);
    push_query(0, 0);
    push_query(UNIT, 0);
    push_query(UNIT / 2, UNIT / 2);
    push_query(UNIT, UNIT);
    push_query(32'h8000_0000, 32'h8000_0000);
    push_query(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_query(32'h8000_0001, 32'h7FFF_FFFE);
    push_cmd(CMD_NONE, 3, 1, 2, 3, 4, 5, 6, 7, 8);
    for (int k = 0; k < 6; k++) push_cmd(CMD_ADD, KIND_RECT, -UNIT, UNIT, UNIT, -UNIT,
                                         0, 0, 0, 0);
    push_cmd(CMD_ADD, KIND_CIRCLE, 0, 0, UNIT, 0, 0, 0, 0, 0);
    push_query(0, 0);
    wait_drained();

    hold_left = 400;
    for (int k = 0; k < 12; k++) push_query(0, 0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 60 : 11) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 60 : 11) : 0;
      push_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      push_random(107);
      wait_drained();
    end

    $display("Covered %0d queries, %0d hits, %0d adds on a full table.",
             query_count, hit_count, full_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

// File: point_in_figure_table_test_top.f
+incdir+hw/rtl
hw/rtl/pift_pkg.sv
hw/rtl/pift_req_if.sv
hw/rtl/pift_rsp_if.sv
hw/rtl/pift_cell.sv
hw/rtl/pift_test.sv
hw/rtl/point_in_figure_table_test_top.sv
dv/point_in_figure_table_test_top_tb.sv
